### rtl/bss_pkg.sv
// ============================================================================
// bss_pkg: shared types and constants for the backend server selector
// Holds the table geometry, the operation, algorithm, status and server state
// codes, the table entry record and the request and result payloads.
// ============================================================================
`default_nettype none
package bss_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int IDX_W       = $clog2(MAX_SERVERS);
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

    localparam logic [31:0] ALL_ONES_32 = 32'hFFFF_FFFF;
    localparam logic [15:0] SAT16_MAX   = 16'hFFFF;

    localparam logic [3:0] OP_SELECT    = 4'd0;
    localparam logic [3:0] OP_ADD       = 4'd1;
    localparam logic [3:0] OP_REMOVE    = 4'd2;
    localparam logic [3:0] OP_DRAIN     = 4'd3;
    localparam logic [3:0] OP_DOWN      = 4'd4;
    localparam logic [3:0] OP_RESTORE   = 4'd5;
    localparam logic [3:0] OP_CHECK     = 4'd6;
    localparam logic [3:0] OP_RESPONSE  = 4'd7;
    localparam logic [3:0] OP_RELEASE   = 4'd8;
    localparam logic [3:0] OP_QUERY     = 4'd9;
    localparam logic [3:0] OP_CHECK_ALL = 4'd10;
    localparam logic [3:0] OP_PEEK      = 4'd11;

    localparam logic [2:0] ALG_ROUND_ROBIN = 3'd0;
    localparam logic [2:0] ALG_LEAST_CONNS = 3'd1;
    localparam logic [2:0] ALG_ADDR_HASH   = 3'd2;
    localparam logic [2:0] ALG_LEAST_RESP  = 3'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    localparam logic [1:0] SRV_ACTIVE   = 2'd0;
    localparam logic [1:0] SRV_DRAINING = 2'd1;
    localparam logic [1:0] SRV_DOWN     = 2'd2;

    localparam logic [2:0] REG_ALGORITHM = 3'd0;
    localparam logic [2:0] REG_MAX_CONNS = 3'd4;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [1:0]  state;
        logic [15:0] conns;
        logic [31:0] avg_resp;
        logic [15:0] failures;
    } entry_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] client_addr;
        logic [4:0]  server_index;
        logic [31:0] backend_addr;
        logic [15:0] backend_port;
        logic [31:0] resp_time_ms;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  chosen_index;
        logic [31:0] chosen_addr;
        logic [15:0] chosen_port;
        logic [1:0]  srv_state;
        logic [15:0] open_conns;
        logic [15:0] fail_count;
        logic        healthy;
        logic [4:0]  healthy_total;
    } res_t;

endpackage
`default_nettype wire

### rtl/bss_table.sv
// ============================================================================
// bss_table: server table memory
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none
module bss_table (
    input  wire logic                 clk,
    input  wire logic [bss_pkg::IDX_W-1:0] rd_addr,
    output bss_pkg::entry_t           rd_data,
    input  wire logic                 wr_en,
    input  wire logic [bss_pkg::IDX_W-1:0] wr_addr,
    input  wire bss_pkg::entry_t      wr_data
);
    import bss_pkg::*;

    entry_t mem [MAX_SERVERS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/bss_mod.sv
// ============================================================================
// bss_mod: iterative remainder unit
// Reduces a 32-bit value modulo the live server count, one bit per cycle.
// ============================================================================
`default_nettype none
module bss_mod (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [31:0]              dividend,
    input  wire logic [bss_pkg::CNT_W-1:0] divisor,
    output logic                          done,
    output logic [bss_pkg::CNT_W-1:0]     remainder
);
    import bss_pkg::*;

    logic [31:0]      num_reg;
    logic [CNT_W-1:0] div_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [5:0]       step_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W:0]   trial;

    // Shift in the next dividend bit and subtract once if it fits.
    always_comb
    begin
        trial = {rem_reg, num_reg[31]};
        if (trial >= {1'b0, div_reg})
        begin
            trial = trial - {1'b0, div_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 6'd1;
                if (step_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[30:0], 1'b0};
            rem_reg <= trial[CNT_W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

### rtl/backend_server_selector.sv
// ============================================================================
// backend_server_selector: load balancer server table and picker
// Keeps up to MAX_SERVERS backend entries and serves select, table management,
// health check, response averaging, release, peek and query requests.
// ============================================================================
// One request is handled at a time and the request channel is not ready until
// the sequencer is back in idle; a finished result waits in an output register
// so the next request can be taken meanwhile. The table is a single-port-read
// memory with registered read data, so every entry visited takes a read state
// and an evaluate state. Round robin and address hash select run a 32-step
// remainder unit. Least connections and least response time select, peek and
// check all scan the table. Remove shifts every entry behind the removed one
// down by a place. A result that still waits for the receiver holds the
// sequencer in its output state. Table contents are undefined until added,
// and only positions below the live count are ever read back.
// ============================================================================
`default_nettype none
module backend_server_selector (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire bss_pkg::req_t req_data,
    output logic             res_valid,
    input  wire logic        res_ready,
    output bss_pkg::res_t    res_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_SCAN_RD,
        S_SCAN_EV,
        S_RD,
        S_MODIFY,
        S_CMP_RD,
        S_CMP_WR,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [2:0]  algorithm_reg;
    logic [15:0] max_conns_reg;

    // Block state.
    logic [CNT_W-1:0] live_reg, live_next;
    logic [31:0]      rotate_reg, rotate_next;

    // Working registers of the sequencer.
    req_t             req_reg;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [31:0]      best_reg, best_next;
    logic [IDX_W-1:0] target_reg, target_next;
    res_t             result_reg, result_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_data_reg, res_data_next;

    // Table and remainder unit connections.
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             mod_start;
    logic [31:0]      mod_dividend;
    logic             mod_done;
    logic [CNT_W-1:0] mod_rem;

    logic   idx_ok;
    logic   cfg_write;
    entry_t upd;
    logic   hc_pass;
    logic [32:0] avg_sum;

    bss_table u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bss_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (live_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Configuration port: always ready, register chosen by the word address.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    always_comb
    begin
        if (paddr[2])
        begin
            prdata = {16'd0, max_conns_reg};
        end
        else
        begin
            prdata = {29'd0, algorithm_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            algorithm_reg <= ALG_ROUND_ROBIN;
            max_conns_reg <= 16'd1024;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
            begin
                max_conns_reg <= pwdata[15:0];
            end
            else
            begin
                algorithm_reg <= pwdata[2:0];
            end
        end
    end

    // Builds a result that reports one entry after the op.
    function automatic res_t entry_result(input logic [CNT_W-1:0] pos, input entry_t e);
        res_t r;
        r              = '0;
        r.status       = ST_OK;
        r.chosen_index = 5'(pos);
        r.chosen_addr  = e.addr;
        r.chosen_port  = e.port;
        r.srv_state    = e.state;
        r.open_conns   = e.conns;
        r.fail_count   = e.failures;
        return r;
    endfunction

    assign idx_ok  = (req_reg.server_index != 5'd0)
                  && (int'(req_reg.server_index) <= int'(live_reg));
    assign hc_pass = {16'd0, rd_data.conns} < {16'd0, max_conns_reg};
    assign avg_sum = {1'b0, rd_data.avg_resp} + {1'b0, req_reg.resp_time_ms};
    assign req_ready = (state_reg == S_IDLE);
    assign mod_dividend = (algorithm_reg == ALG_ROUND_ROBIN) ? rotate_reg
                                                               : req_reg.client_addr;

    // Entry after a per-server op, select or peek.
    always_comb
    begin
        upd = rd_data;
        case (req_reg.op)
            OP_SELECT:
            begin
                if (rd_data.conns != SAT16_MAX)
                begin
                    upd.conns = rd_data.conns + 16'd1;
                end
            end
            OP_DRAIN:
            begin
                upd.state = SRV_DRAINING;
            end
            OP_DOWN:
            begin
                upd.state = SRV_DOWN;
                if (rd_data.failures != SAT16_MAX)
                begin
                    upd.failures = rd_data.failures + 16'd1;
                end
            end
            OP_RESTORE:
            begin
                upd.state    = SRV_ACTIVE;
                upd.failures = 16'd0;
            end
            OP_CHECK:
            begin
                if (hc_pass)
                begin
                    upd.state    = SRV_ACTIVE;
                    upd.failures = 16'd0;
                end
            end
            OP_RESPONSE:
            begin
                upd.avg_resp = avg_sum[32:1];
            end
            OP_RELEASE:
            begin
                if (rd_data.conns != 16'd0)
                begin
                    upd.conns = rd_data.conns - 16'd1;
                end
            end
            default:
            begin
                upd = rd_data;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        live_next      = live_reg;
        rotate_next    = rotate_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        best_next      = best_reg;
        target_next    = target_reg;
        result_next    = result_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        rd_addr        = target_reg;
        wr_en          = 1'b0;
        wr_addr        = target_reg;
        wr_data        = upd;
        mod_start      = 1'b0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                result_next = '0;
                k_next      = '0;
                pos_next    = '0;
                total_next  = '0;
                best_next   = ALL_ONES_32;
                target_next = IDX_W'(req_reg.server_index - 5'd1);
                state_next  = S_OUT;
                if (req_reg.op >= OP_REMOVE && req_reg.op <= OP_QUERY && !idx_ok)
                begin
                    result_next.status = ST_BAD_INDEX;
                end
                else
                begin
                    case (req_reg.op)
                        OP_SELECT, OP_PEEK:
                        begin
                            if (live_reg == '0)
                            begin
                                result_next.status = ST_NONE;
                            end
                            else if (req_reg.op == OP_PEEK
                                     || algorithm_reg == ALG_LEAST_CONNS
                                     || algorithm_reg == ALG_LEAST_RESP)
                            begin
                                state_next = S_SCAN_RD;
                            end
                            else if (algorithm_reg == ALG_ROUND_ROBIN
                                     || algorithm_reg == ALG_ADDR_HASH)
                            begin
                                mod_start  = 1'b1;
                                state_next = S_DIV;
                                if (algorithm_reg == ALG_ROUND_ROBIN)
                                begin
                                    rotate_next = rotate_reg + 32'd1;
                                end
                            end
                            else
                            begin
                                target_next = '0;
                                state_next  = S_RD;
                            end
                        end
                        OP_ADD:
                        begin
                            if (int'(live_reg) >= MAX_SERVERS)
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en            = 1'b1;
                                wr_addr          = IDX_W'(live_reg);
                                wr_data          = '0;
                                wr_data.addr     = req_reg.backend_addr;
                                wr_data.port     = req_reg.backend_port;
                                wr_data.state    = SRV_ACTIVE;
                                live_next        = live_reg + CNT_W'(1);
                                result_next      = entry_result(live_next, wr_data);
                            end
                        end
                        OP_REMOVE:
                        begin
                            k_next     = CNT_W'(req_reg.server_index - 5'd1);
                            state_next = S_CMP_RD;
                        end
                        OP_CHECK_ALL:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        OP_DRAIN, OP_DOWN, OP_RESTORE, OP_CHECK,
                        OP_RESPONSE, OP_RELEASE, OP_QUERY:
                        begin
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (mod_done)
                begin
                    target_next = IDX_W'(mod_rem);
                    state_next  = S_RD;
                end
            end
            S_SCAN_RD:
            begin
                rd_addr = IDX_W'(k_reg);
                if (k_reg == live_reg)
                begin
                    if (req_reg.op == OP_CHECK_ALL)
                    begin
                        result_next.healthy_total = 5'(total_reg);
                        state_next = S_OUT;
                    end
                    else if (pos_reg == '0)
                    begin
                        result_next.status = ST_NONE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        target_next = IDX_W'(pos_reg - CNT_W'(1));
                        state_next  = S_RD;
                    end
                end
                else
                begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                k_next     = k_reg + CNT_W'(1);
                state_next = S_SCAN_RD;
                if (req_reg.op == OP_CHECK_ALL)
                begin
                    if (hc_pass)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = IDX_W'(k_reg);
                        wr_data        = rd_data;
                        wr_data.state  = SRV_ACTIVE;
                        wr_data.failures = 16'd0;
                        total_next     = total_reg + CNT_W'(1);
                    end
                end
                else if (req_reg.op == OP_SELECT && algorithm_reg == ALG_LEAST_RESP)
                begin
                    if (rd_data.state == SRV_ACTIVE && rd_data.avg_resp < best_reg)
                    begin
                        best_next = rd_data.avg_resp;
                        pos_next  = k_next;
                    end
                end
                else
                begin
                    if (rd_data.state == SRV_ACTIVE && {16'd0, rd_data.conns} < best_reg)
                    begin
                        best_next = {16'd0, rd_data.conns};
                        pos_next  = k_next;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                wr_en       = 1'b1;
                result_next = entry_result(CNT_W'(target_reg) + CNT_W'(1), upd);
                if (req_reg.op == OP_CHECK)
                begin
                    result_next.healthy = hc_pass;
                end
                state_next = S_OUT;
            end
            S_CMP_RD:
            begin
                rd_addr = IDX_W'(k_reg + CNT_W'(1));
                if (k_reg + CNT_W'(1) < live_reg)
                begin
                    state_next = S_CMP_WR;
                end
                else
                begin
                    live_next  = live_reg - CNT_W'(1);
                    state_next = S_OUT;
                end
            end
            S_CMP_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(k_reg);
                wr_data    = rd_data;
                k_next     = k_reg + CNT_W'(1);
                state_next = S_CMP_RD;
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            rotate_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            rotate_reg    <= rotate_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req_data;
        end
        k_reg        <= k_next;
        pos_reg      <= pos_next;
        total_reg    <= total_next;
        best_reg     <= best_next;
        target_reg   <= target_next;
        result_reg   <= result_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

`ifndef SYNTHESIS
    a_live_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(live_reg) <= MAX_SERVERS)
        else $error("live count above table size");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req_ready)
        else $error("ready while a request is in progress");

    a_fail_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.status != ST_OK) |-> (res_data.chosen_index == 5'd0))
        else $error("failed result carries an index");

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");
`endif

endmodule
`default_nettype wire
